FILE: hdl/sdfpe_pkg.sv
// Shared types, constants and helper functions of the signed distance primitive evaluator.
// Used by every module of the block but sdfpe_delay; it depends on nothing else.
package sdfpe_pkg;

  localparam int WORD_BITS = 32;

  localparam int VAL_W    = 36;
  localparam int MAG_W    = 34;
  localparam int HALF_W   = MAG_W / 2;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 72;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQRT_STG = ROOT_W / 2;
  localparam int LEN_LAT  = 4 + SQRT_STG;
  localparam int LAT      = 8 + 2 * LEN_LAT;

  localparam logic [2:0] FN_SPHERE = 3'd0;
  localparam logic [2:0] FN_BOX    = 3'd1;
  localparam logic [2:0] FN_FRAME  = 3'd2;
  localparam logic [2:0] FN_RBOX   = 3'd3;
  localparam logic [2:0] FN_TORUS  = 3'd4;
  localparam logic [2:0] FN_CAPS   = 3'd5;
  localparam logic [2:0] FN_CYL    = 3'd6;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam longint SAT_HI_L = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint SAT_LO_L = -SAT_HI_L - 1;
  localparam val_t   SAT_HI   = val_t'(SAT_HI_L);
  localparam val_t   SAT_LO   = val_t'(SAT_LO_L);

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        dim_a;
    logic [30:0]        dim_b;
    logic [30:0]        dim_c;
    logic [30:0]        dim_d;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    val_t x;
    val_t y;
    val_t z;
  } vec_t;

  typedef struct packed {
    logic [2:0] func;
    val_t       off0;
    val_t       off1;
    val_t       off2;
    val_t       y;
    val_t       d;
    val_t       b;
  } ctx1_t;

  typedef struct packed {
    logic [2:0] func;
    val_t       pr;
    val_t       off;
  } ctx2_t;

  function automatic val_t absv(val_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic val_t pos0(val_t v);
    return (v > 0) ? v : '0;
  endfunction

  function automatic val_t max2(val_t a, val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic val_t min2(val_t a, val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: hdl/sdf_primitive_evaluator_top.sv
// Top level of the signed distance primitive evaluator: front end, two length passes, result.
// Uses sdfpe_pkg, sdfpe_front, sdfpe_len and sdfpe_delay.
//
// A query beat is taken on in_beat at a rising edge where start is high and busy is low.
// busy is high only while rst_n is low, so after reset one beat can enter in every cycle.
// Each beat gives exactly one result on out_beat, marked by out_strobe for one cycle.
// Results leave in the order the beats came in. The path holds two length pipelines
// of 22 stages each in series (four for squaring and summing, 18 for the square root):
// the first forms the primary length for every shape, the second the outer length of
// the torus and the rounded cylinder. All beats follow the same path, so the
// throughput is one beat per cycle.
// The receiver cannot stall; a result is on the outputs for one cycle only.
// Synchronous reset empties the pipeline: every valid bit is cleared and no strobe
// appears until new beats are accepted. Func code 7 returns distance 0, not saturated.
module sdf_primitive_evaluator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sdfpe_pkg::in_beat_t  in_beat,
  output logic                 out_strobe,
  output sdfpe_pkg::out_beat_t out_beat
);

  localparam int ROOT_W = sdfpe_pkg::ROOT_W;
  localparam int C1_W   = $bits(sdfpe_pkg::ctx1_t);
  localparam int C2_W   = $bits(sdfpe_pkg::ctx2_t);

  logic              fe_v;
  sdfpe_pkg::vec_t   fe_l0, fe_l1, fe_l2;
  sdfpe_pkg::ctx1_t  fe_ctx;

  logic [ROOT_W-1:0] len0, len1, len2, len3;
  logic              d1_v;
  sdfpe_pkg::ctx1_t  d1_ctx;

  logic              m1_v_r;
  sdfpe_pkg::ctx1_t  m1_ctx_r;
  sdfpe_pkg::val_t   s0_r, s1_r, s2_r;

  logic              m2_v_r;
  sdfpe_pkg::vec_t   m2_vec_r, m2_vec_nxt;
  sdfpe_pkg::ctx2_t  m2_ctx_r, m2_ctx_nxt;

  logic              d2_v;
  sdfpe_pkg::ctx2_t  d2_ctx;

  logic              f1_v_r;
  sdfpe_pkg::val_t   f1_r, f1_nxt;

  logic                 out_v_r;
  sdfpe_pkg::out_beat_t out_r, out_nxt;

  assign busy = ~rst_n;

  sdfpe_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (start & ~busy),
    .beat  (in_beat),
    .vld_o (fe_v),
    .lane0 (fe_l0),
    .lane1 (fe_l1),
    .lane2 (fe_l2),
    .ctx   (fe_ctx)
  );

  sdfpe_len u_len0 (.clk(clk), .vin(fe_l0), .root(len0));
  sdfpe_len u_len1 (.clk(clk), .vin(fe_l1), .root(len1));
  sdfpe_len u_len2 (.clk(clk), .vin(fe_l2), .root(len2));

  sdfpe_delay #(.W(C1_W), .DEPTH(sdfpe_pkg::LEN_LAT)) u_dly1 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (fe_v),
    .dat_i (fe_ctx),
    .vld_o (d1_v),
    .dat_o (d1_ctx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      f1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      m1_v_r  <= d1_v;
      m2_v_r  <= m1_v_r;
      f1_v_r  <= d2_v;
      out_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_ctx_r <= d1_ctx;
    s0_r     <= sdfpe_pkg::val_t'(len0) + d1_ctx.off0;
    s1_r     <= sdfpe_pkg::val_t'(len1) + d1_ctx.off1;
    s2_r     <= sdfpe_pkg::val_t'(len2) + d1_ctx.off2;
  end

  always_comb begin
    m2_vec_nxt      = '0;
    m2_ctx_nxt      = '0;
    m2_ctx_nxt.func = m1_ctx_r.func;
    unique case (m1_ctx_r.func)
      sdfpe_pkg::FN_SPHERE, sdfpe_pkg::FN_BOX, sdfpe_pkg::FN_CAPS: begin
        m2_ctx_nxt.pr = s0_r;
      end
      sdfpe_pkg::FN_RBOX: begin
        m2_ctx_nxt.pr = s0_r - m1_ctx_r.d;
      end
      sdfpe_pkg::FN_FRAME: begin
        m2_ctx_nxt.pr = sdfpe_pkg::min2(sdfpe_pkg::min2(s0_r, s1_r), s2_r);
      end
      sdfpe_pkg::FN_TORUS: begin
        m2_vec_nxt.x   = s0_r;
        m2_vec_nxt.y   = m1_ctx_r.y;
        m2_ctx_nxt.off = -m1_ctx_r.b;
      end
      sdfpe_pkg::FN_CYL: begin
        m2_vec_nxt.x   = sdfpe_pkg::pos0(s0_r);
        m2_vec_nxt.y   = sdfpe_pkg::pos0(m1_ctx_r.y);
        m2_ctx_nxt.off = sdfpe_pkg::min2(sdfpe_pkg::max2(s0_r, m1_ctx_r.y), '0)
                         - m1_ctx_r.b;
      end
      default: begin
        m2_ctx_nxt.pr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    m2_vec_r <= m2_vec_nxt;
    m2_ctx_r <= m2_ctx_nxt;
  end

  sdfpe_len u_len3 (.clk(clk), .vin(m2_vec_r), .root(len3));

  sdfpe_delay #(.W(C2_W), .DEPTH(sdfpe_pkg::LEN_LAT)) u_dly2 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (m2_v_r),
    .dat_i (m2_ctx_r),
    .vld_o (d2_v),
    .dat_o (d2_ctx)
  );

  always_comb begin
    if (d2_ctx.func == sdfpe_pkg::FN_TORUS || d2_ctx.func == sdfpe_pkg::FN_CYL) begin
      f1_nxt = sdfpe_pkg::val_t'(len3) + d2_ctx.off;
    end else begin
      f1_nxt = d2_ctx.pr;
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= f1_nxt;
  end

  always_comb begin
    priority if (f1_r > sdfpe_pkg::SAT_HI) begin
      out_nxt.distance  = sdfpe_pkg::SAT_HI[31:0];
      out_nxt.saturated = 1'b1;
    end else if (f1_r < sdfpe_pkg::SAT_LO) begin
      out_nxt.distance  = sdfpe_pkg::SAT_LO[31:0];
      out_nxt.saturated = 1'b1;
    end else begin
      out_nxt.distance  = f1_r[31:0];
      out_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_beat   = out_r;

endmodule

FILE: hdl/sdfpe_delay.sv
// Delay line that carries a valid bit and a side payload alongside a fixed-latency unit.
// Depends on nothing but its parameters.
module sdfpe_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    dat_r[0] <= dat_i;
    for (int i = 1; i < DEPTH; i++) begin
      dat_r[i] <= dat_r[i-1];
    end
  end

  assign vld_o = vld_r[DEPTH-1];
  assign dat_o = dat_r[DEPTH-1];

endmodule

FILE: hdl/sdfpe_len.sv
// Pipelined Euclidean length of a three-element vector: split squares, a sum and a
// two-bits-per-stage integer square root. Uses sdfpe_pkg.
module sdfpe_len (
  input  logic                          clk,
  input  sdfpe_pkg::vec_t               vin,
  output logic [sdfpe_pkg::ROOT_W-1:0]  root
);

  localparam int MAG_W    = sdfpe_pkg::MAG_W;
  localparam int HALF_W   = sdfpe_pkg::HALF_W;
  localparam int SQ_W     = sdfpe_pkg::SQ_W;
  localparam int SUM_W    = sdfpe_pkg::SUM_W;
  localparam int ROOT_W   = sdfpe_pkg::ROOT_W;
  localparam int REM_W    = sdfpe_pkg::REM_W;
  localparam int SQRT_STG = sdfpe_pkg::SQRT_STG;

  sdfpe_pkg::val_t     elem [3];
  logic [MAG_W-1:0]    mag_r [3];
  logic [2*HALF_W-1:0] ll_r [3];
  logic [2*HALF_W-1:0] hl_r [3];
  logic [2*HALF_W-1:0] hh_r [3];
  logic [SQ_W-1:0]     sq_r [3];
  logic [SUM_W-1:0]    rad_r  [SQRT_STG+1];
  logic [REM_W-1:0]    rem_r  [1:SQRT_STG];
  logic [ROOT_W-1:0]   root_r [1:SQRT_STG];

  assign elem[0] = vin.x;
  assign elem[1] = vin.y;
  assign elem[2] = vin.z;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= MAG_W'(sdfpe_pkg::absv(elem[k]));
      ll_r[k]  <= (2*HALF_W)'(mag_r[k][HALF_W-1:0]) * (2*HALF_W)'(mag_r[k][HALF_W-1:0]);
      hl_r[k]  <= (2*HALF_W)'(mag_r[k][MAG_W-1:HALF_W]) * (2*HALF_W)'(mag_r[k][HALF_W-1:0]);
      hh_r[k]  <= (2*HALF_W)'(mag_r[k][MAG_W-1:HALF_W])
                  * (2*HALF_W)'(mag_r[k][MAG_W-1:HALF_W]);
      sq_r[k]  <= (SQ_W'(hh_r[k]) << (2 * HALF_W)) + (SQ_W'(hl_r[k]) << (HALF_W + 1))
                  + SQ_W'(ll_r[k]);
    end
    rad_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  for (genvar i = 0; i < SQRT_STG; i++) begin : g_sqrt
    logic [SUM_W-1:0]  rad_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_r[i];
      assign root_in = root_r[i];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      rad_nxt  = rad_r[i];
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int j = 0; j < 2; j++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[SUM_W-1:SUM_W-2]};
        rad_nxt = {rad_nxt[SUM_W-3:0], 2'b00};
        trial   = REM_W'({root_nxt, 2'b01});
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i+1]  <= rad_nxt;
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
    end
  end

  assign root = root_r[SQRT_STG];

endmodule

FILE: hdl/sdfpe_front.sv
// Front end: input register, box offsets and per-shape selection of the first length vectors.
// Uses sdfpe_pkg; feeds three sdfpe_len lanes and the context delay line.
module sdfpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  sdfpe_pkg::in_beat_t beat,
  output logic                vld_o,
  output sdfpe_pkg::vec_t     lane0,
  output sdfpe_pkg::vec_t     lane1,
  output sdfpe_pkg::vec_t     lane2,
  output sdfpe_pkg::ctx1_t    ctx
);

  logic                v0_r, v1_r, v2_r, v3_r;
  sdfpe_pkg::in_beat_t b0_r;

  logic [2:0]          f1_r, f2_r;
  sdfpe_pkg::vec_t     p1_r, e1_r, p2_r, e2_r;
  sdfpe_pkg::val_t     a1_r, b1_r, c1_r, d1_r, cy1_r;
  sdfpe_pkg::val_t     a2_r, b2_r, d2_r, cy2_r, yc2_r;
  sdfpe_pkg::vec_t     g2_r, h2_r;

  sdfpe_pkg::vec_t     p1_nxt, e1_nxt;
  sdfpe_pkg::val_t     a1_nxt, c1_nxt, d1_nxt;
  sdfpe_pkg::vec_t     g2_nxt, h2_nxt;
  sdfpe_pkg::val_t     yc2_nxt;

  sdfpe_pkg::vec_t     l0_nxt, l1_nxt, l2_nxt;
  sdfpe_pkg::ctx1_t    ctx_nxt;
  sdfpe_pkg::vec_t     l0_r, l1_r, l2_r;
  sdfpe_pkg::ctx1_t    ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    p1_nxt.x = sdfpe_pkg::val_t'(b0_r.pos_x);
    p1_nxt.y = sdfpe_pkg::val_t'(b0_r.pos_y);
    p1_nxt.z = sdfpe_pkg::val_t'(b0_r.pos_z);
    a1_nxt   = sdfpe_pkg::val_t'(b0_r.dim_a);
    c1_nxt   = sdfpe_pkg::val_t'(b0_r.dim_c);
    d1_nxt   = sdfpe_pkg::val_t'(b0_r.dim_d);
    e1_nxt.x = sdfpe_pkg::absv(p1_nxt.x) - a1_nxt;
    e1_nxt.y = sdfpe_pkg::absv(p1_nxt.y) - sdfpe_pkg::val_t'(b0_r.dim_b);
    e1_nxt.z = sdfpe_pkg::absv(p1_nxt.z) - c1_nxt;
  end

  always_ff @(posedge clk) begin
    b0_r  <= beat;
    f1_r  <= b0_r.func;
    p1_r  <= p1_nxt;
    e1_r  <= e1_nxt;
    a1_r  <= a1_nxt;
    b1_r  <= sdfpe_pkg::val_t'(b0_r.dim_b);
    c1_r  <= c1_nxt;
    d1_r  <= d1_nxt;
    cy1_r <= sdfpe_pkg::absv(p1_nxt.y) - c1_nxt;
  end

  always_comb begin
    h2_nxt.x = e1_r.x + d1_r;
    h2_nxt.y = e1_r.y + d1_r;
    h2_nxt.z = e1_r.z + d1_r;
    g2_nxt.x = sdfpe_pkg::absv(h2_nxt.x) - d1_r;
    g2_nxt.y = sdfpe_pkg::absv(h2_nxt.y) - d1_r;
    g2_nxt.z = sdfpe_pkg::absv(h2_nxt.z) - d1_r;
    if (p1_r.y < 0) begin
      yc2_nxt = p1_r.y;
    end else if (p1_r.y > c1_r) begin
      yc2_nxt = p1_r.y - c1_r;
    end else begin
      yc2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    f2_r  <= f1_r;
    p2_r  <= p1_r;
    e2_r  <= e1_r;
    a2_r  <= a1_r;
    b2_r  <= b1_r;
    d2_r  <= d1_r;
    cy2_r <= cy1_r;
    g2_r  <= g2_nxt;
    h2_r  <= h2_nxt;
    yc2_r <= yc2_nxt;
  end

  always_comb begin
    l0_nxt       = '0;
    l1_nxt       = '0;
    l2_nxt       = '0;
    ctx_nxt      = '0;
    ctx_nxt.func = f2_r;
    ctx_nxt.d    = d2_r;
    ctx_nxt.b    = b2_r;
    unique case (f2_r)
      sdfpe_pkg::FN_SPHERE: begin
        l0_nxt       = p2_r;
        ctx_nxt.off0 = -d2_r;
      end
      sdfpe_pkg::FN_BOX: begin
        l0_nxt.x     = sdfpe_pkg::pos0(e2_r.x);
        l0_nxt.y     = sdfpe_pkg::pos0(e2_r.y);
        l0_nxt.z     = sdfpe_pkg::pos0(e2_r.z);
        ctx_nxt.off0 = sdfpe_pkg::min2(sdfpe_pkg::max2(e2_r.x,
                         sdfpe_pkg::max2(e2_r.y, e2_r.z)), '0);
      end
      sdfpe_pkg::FN_FRAME: begin
        l0_nxt.x     = sdfpe_pkg::pos0(e2_r.x);
        l0_nxt.y     = sdfpe_pkg::pos0(g2_r.y);
        l0_nxt.z     = sdfpe_pkg::pos0(g2_r.z);
        l1_nxt.x     = sdfpe_pkg::pos0(g2_r.x);
        l1_nxt.y     = sdfpe_pkg::pos0(e2_r.y);
        l1_nxt.z     = sdfpe_pkg::pos0(g2_r.z);
        l2_nxt.x     = sdfpe_pkg::pos0(g2_r.x);
        l2_nxt.y     = sdfpe_pkg::pos0(g2_r.y);
        l2_nxt.z     = sdfpe_pkg::pos0(e2_r.z);
        ctx_nxt.off0 = sdfpe_pkg::min2(sdfpe_pkg::max2(e2_r.x,
                         sdfpe_pkg::max2(g2_r.y, g2_r.z)), '0);
        ctx_nxt.off1 = sdfpe_pkg::min2(sdfpe_pkg::max2(g2_r.x,
                         sdfpe_pkg::max2(e2_r.y, g2_r.z)), '0);
        ctx_nxt.off2 = sdfpe_pkg::min2(sdfpe_pkg::max2(g2_r.x,
                         sdfpe_pkg::max2(g2_r.y, e2_r.z)), '0);
      end
      sdfpe_pkg::FN_RBOX: begin
        l0_nxt.x     = sdfpe_pkg::pos0(h2_r.x);
        l0_nxt.y     = sdfpe_pkg::pos0(h2_r.y);
        l0_nxt.z     = sdfpe_pkg::pos0(h2_r.z);
        ctx_nxt.off0 = sdfpe_pkg::min2(sdfpe_pkg::max2(h2_r.x,
                         sdfpe_pkg::max2(h2_r.y, h2_r.z)), '0);
      end
      sdfpe_pkg::FN_TORUS: begin
        l0_nxt.x     = p2_r.x;
        l0_nxt.z     = p2_r.z;
        ctx_nxt.off0 = -a2_r;
        ctx_nxt.y    = p2_r.y;
      end
      sdfpe_pkg::FN_CAPS: begin
        l0_nxt.x     = p2_r.x;
        l0_nxt.y     = yc2_r;
        l0_nxt.z     = p2_r.z;
        ctx_nxt.off0 = -a2_r;
      end
      sdfpe_pkg::FN_CYL: begin
        l0_nxt.x     = p2_r.x;
        l0_nxt.z     = p2_r.z;
        ctx_nxt.off0 = b2_r - (a2_r <<< 1);
        ctx_nxt.y    = cy2_r;
      end
      default: begin
        l0_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    l0_r  <= l0_nxt;
    l1_r  <= l1_nxt;
    l2_r  <= l2_nxt;
    ctx_r <= ctx_nxt;
  end

  assign vld_o = v3_r;
  assign lane0 = l0_r;
  assign lane1 = l1_r;
  assign lane2 = l2_r;
  assign ctx   = ctx_r;

endmodule

FILE: hdl/sdfpe_checker.sv
// Port-level checker for the signed distance primitive evaluator and its bind statement.
// Uses sdfpe_pkg; attaches to sdf_primitive_evaluator_top.
module sdfpe_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input sdfpe_pkg::out_beat_t out_beat
);

  localparam int LAT = sdfpe_pkg::LAT;

  a_busy_low: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy is high outside reset");

  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, LAT) |-> (out_strobe == $past(start && !busy, LAT)))
    else $error("result strobe does not match an accepted beat");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.saturated) |->
      (out_beat.distance == 32'sh7fffffff || out_beat.distance == 32'sh80000000))
    else $error("saturated result is not at a range limit");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

endmodule

bind sdf_primitive_evaluator_top sdfpe_checker u_sdfpe_checker (.*);

FILE: tb/sdf_primitive_evaluator_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the signed distance primitive evaluator: directed table, then random queries.
// Depends on sdfpe_pkg and sdf_primitive_evaluator_top; results are predicted in-line.
module sdf_primitive_evaluator_top_tb;

  localparam int WATCHDOG = 4000;
  localparam int NUM_RANDOM = 700;
  localparam longint DIST_HI = 64'sd2147483647;
  localparam longint DIST_LO = -64'sd2147483648;

  typedef struct {
    sdfpe_pkg::in_beat_t  beat;
    logic                 has_fixed;
    sdfpe_pkg::out_beat_t fixed;
  } query_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  sdfpe_pkg::in_beat_t  in_beat = '0;
  logic                 out_strobe;
  sdfpe_pkg::out_beat_t out_beat;

  sdfpe_pkg::out_beat_t pending_dist[$];
  query_row_t           dir_rows[$];
  int                   mismatches = 0;
  int                   idle_cycles = 0;
  int                   gap_pct = 11;
  bit                   timed_out = 1'b0;

  sdf_primitive_evaluator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_strobe(out_strobe), .out_beat(out_beat)
  );

  always #1 clk = ~clk;

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint pos_part(longint v);
    return (v > 0) ? v : 0;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint vec_len(longint a, longint b, longint c);
    logic [79:0] norm;
    logic [79:0] trial;
    logic [39:0] root;
    norm = 80'(mag_of(a)) * 80'(mag_of(a)) + 80'(mag_of(b)) * 80'(mag_of(b))
         + 80'(mag_of(c)) * 80'(mag_of(c));
    root = '0;
    for (int i = 35; i >= 0; i--) begin
      trial = 80'(root | (40'd1 << i));
      if (trial * trial <= norm) root = root | (40'd1 << i);
    end
    return longint'(root);
  endfunction

  function automatic longint box_dist(longint qx, longint qy, longint qz);
    return vec_len(pos_part(qx), pos_part(qy), pos_part(qz)) + lmin(lmax(qx, lmax(qy, qz)), 0);
  endfunction

  function automatic sdfpe_pkg::out_beat_t predict_distance(sdfpe_pkg::in_beat_t q);
    longint px, py, pz, a, b, c, d, r, ex, ey, ez, qx, qy, qz, cl, dx, dy;
    sdfpe_pkg::out_beat_t res;
    px = longint'(q.pos_x); py = longint'(q.pos_y); pz = longint'(q.pos_z);
    a = longint'(q.dim_a); b = longint'(q.dim_b);
    c = longint'(q.dim_c); d = longint'(q.dim_d);
    r = 0;
    case (q.func)
      sdfpe_pkg::FN_SPHERE: r = vec_len(px, py, pz) - d;
      sdfpe_pkg::FN_BOX:    r = box_dist(mag_of(px) - a, mag_of(py) - b, mag_of(pz) - c);
      sdfpe_pkg::FN_FRAME: begin
        ex = mag_of(px) - a; ey = mag_of(py) - b; ez = mag_of(pz) - c;
        qx = mag_of(ex + d) - d; qy = mag_of(ey + d) - d; qz = mag_of(ez + d) - d;
        r = lmin(lmin(box_dist(ex, qy, qz), box_dist(qx, ey, qz)), box_dist(qx, qy, ez));
      end
      sdfpe_pkg::FN_RBOX:
        r = box_dist(mag_of(px) - a + d, mag_of(py) - b + d, mag_of(pz) - c + d) - d;
      sdfpe_pkg::FN_TORUS: r = vec_len(vec_len(px, pz, 0) - a, py, 0) - b;
      sdfpe_pkg::FN_CAPS: begin
        cl = (py < 0) ? 0 : ((py > c) ? c : py);
        r = vec_len(px, py - cl, pz) - a;
      end
      sdfpe_pkg::FN_CYL: begin
        dx = vec_len(px, pz, 0) - 2 * a + b;
        dy = mag_of(py) - c;
        r = lmin(lmax(dx, dy), 0) + vec_len(pos_part(dx), pos_part(dy), 0) - b;
      end
      default: r = 0;
    endcase
    res.saturated = 1'b0;
    if (r > DIST_HI) begin
      r = DIST_HI;
      res.saturated = 1'b1;
    end
    if (r < DIST_LO) begin
      r = DIST_LO;
      res.saturated = 1'b1;
    end
    res.distance = r[31:0];
    return res;
  endfunction

  function automatic sdfpe_pkg::in_beat_t make_query(logic [2:0] f, int x, int y, int z,
                                                     int a, int b, int c, int d);
    sdfpe_pkg::in_beat_t q;
    q.func = f; q.pos_x = x; q.pos_y = y; q.pos_z = z;
    q.dim_a = a[30:0]; q.dim_b = b[30:0]; q.dim_c = c[30:0]; q.dim_d = d[30:0];
    return q;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 3))
      0: return $urandom() & 32'h7FFF_FFFF;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 0;
      default: return $urandom_range(0, 32'h0080_0000);
    endcase
  endfunction

  task automatic send_query(sdfpe_pkg::in_beat_t q, logic has_fixed,
                            sdfpe_pkg::out_beat_t fixed);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_beat <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dist.push_back(has_fixed ? fixed : predict_distance(q));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    sdfpe_pkg::out_beat_t want;
    if (rst_n && out_strobe) begin
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_beat);
      end else begin
        want = pending_dist.pop_front();
        if (want.distance !== out_beat.distance || want.saturated !== out_beat.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: distance exp %h got %h, saturated exp %b got %b",
                     want.distance, out_beat.distance, want.saturated, out_beat.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) timed_out = 1'b1;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sdfpe_pkg::out_beat_t zero_res;
    sdfpe_pkg::out_beat_t sat_hi;
    int drain;
    zero_res = '0;
    sat_hi.distance = 32'h7FFF_FFFF; sat_hi.saturated = 1'b1;
    dir_rows = '{
      '{make_query(sdfpe_pkg::FN_SPHERE, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res},
      '{make_query(3'd7, -1, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2, 3), 1'b1, zero_res},
      '{make_query(sdfpe_pkg::FN_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        0, 0, 0, 0), 1'b1, sat_hi},
      '{make_query(sdfpe_pkg::FN_SPHERE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_BOX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        0, 0, 0, 0), 1'b1, sat_hi},
      '{make_query(sdfpe_pkg::FN_BOX, 32'h0001_0000, -32'h0002_0000, 0, 32'h0003_0000,
        32'h0003_0000, 32'h0003_0000, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_FRAME, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
        32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0000_4000), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0,
        32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_RBOX, 5, -7, 9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_RBOX, 32'h0005_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
        32'h0001_0000, 32'h0000_8000), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_TORUS, 32'h0003_0000, 0, 0, 32'h0002_0000, 32'h0000_8000,
        0, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_TORUS, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_TORUS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        0, 0, 0, 0), 1'b1, sat_hi},
      '{make_query(sdfpe_pkg::FN_CAPS, 0, -32'h0001_0000, 0, 32'h0000_8000, 0,
        32'h0002_0000, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CAPS, 0, 32'h0001_0000, 0, 32'h0000_8000, 0,
        32'h0002_0000, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CAPS, 0, 32'h0005_0000, 0, 32'h0000_8000, 0,
        32'h0002_0000, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CAPS, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0,
        32'h7FFF_FFFF, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CYL, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0),
        1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CYL, 32'h0003_0000, 32'h0001_0000, 0, 32'h0001_0000,
        32'h0000_4000, 32'h0002_0000, 0), 1'b0, zero_res},
      '{make_query(sdfpe_pkg::FN_CYL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
        32'h7FFF_FFFF, 0, 0), 1'b0, zero_res}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_query(dir_rows[i].beat, dir_rows[i].has_fixed, dir_rows[i].fixed);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) gap_pct = 63;
      if (n == 2 * NUM_RANDOM / 3) gap_pct = 0;
      send_query(make_query(3'($urandom_range(0, 7)), rand_coord(), rand_coord(), rand_coord(),
                            rand_dim(), rand_dim(), rand_dim(), rand_dim()), 1'b0, zero_res);
    end
    start <= 1'b0;
    drain = 0;
    while (pending_dist.size() != 0) @(posedge clk);
    while (drain < sdfpe_pkg::LAT + 10) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
